// ===== rtl/core/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants for the UTF-8 to UTF-16 decoder
// Lead byte classes, the job record that links the front end to the back end,
// and the fixed code values of the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // Default depth of the job queue between front and back end
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // Encoded value equals the sequence length in bytes
  typedef enum logic [2:0] {
    LC_BAD   = 3'd0,
    LC_ONE   = 3'd1,
    LC_TWO   = 3'd2,
    LC_THREE = 3'd3,
    LC_FOUR  = 3'd4
  } lead_class_t;

  // One decode request: up to four bytes, lead first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;   // index of the final byte (byte count - 1)
    logic            text_last;  // request closes the string
  } job_t;

  function automatic lead_class_t lead_class(input logic [7:0] b);
    lead_class_t c;
    unique casez (b)
      8'b0???????: c = LC_ONE;
      8'b110?????: c = LC_TWO;
      8'b1110????: c = LC_THREE;
      8'b11110???: c = LC_FOUR;
      default:     c = LC_BAD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front: byte intake and sequence assembly
// Holds the bytes of an open sequence and issues one decode request when the
// sequence completes, a single byte stands alone, or the string ends.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         byte_value,
  input  wire logic               last_byte,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    push,
  output u8u16_pkg::job_t         push_job
);

  logic [7:0]              held_bytes [3];
  logic [1:0]              held_count;
  u8u16_pkg::lead_class_t  needed_total;
  u8u16_pkg::lead_class_t  cls;
  logic                    accept;
  logic                    hold;
  logic                    is_lead;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cls      = u8u16_pkg::lead_class(byte_value);
  assign is_lead  = (cls == u8u16_pkg::LC_TWO) || (cls == u8u16_pkg::LC_THREE) ||
                    (cls == u8u16_pkg::LC_FOUR);

  // Keep collecting while the string goes on and the sequence is short
  always_comb begin
    if (last_byte) begin
      hold = 1'b0;
    end else if (held_count == 2'd0) begin
      hold = is_lead;
    end else begin
      hold = (({1'b0, held_count} + 3'd1) < 3'(needed_total));
    end
  end

  assign push = accept && !hold;

  always_comb begin
    push_job.bytes[0]  = (held_count > 2'd0) ? held_bytes[0] : byte_value;
    push_job.bytes[1]  = (held_count > 2'd1) ? held_bytes[1] : byte_value;
    push_job.bytes[2]  = (held_count > 2'd2) ? held_bytes[2] : byte_value;
    push_job.bytes[3]  = byte_value;
    push_job.last_idx  = held_count;
    push_job.text_last = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_total <= u8u16_pkg::LC_BAD;
    end else if (accept) begin
      if (hold) begin
        held_count <= held_count + 2'd1;
        if (held_count == 2'd0) begin
          needed_total <= cls;
        end
      end else begin
        held_count   <= 2'd0;
        needed_total <= u8u16_pkg::LC_BAD;
      end
    end
  end

  // held_count never exceeds 2 while holding
  always_ff @(posedge clk) begin
    if (accept && hold) begin
      held_bytes[held_count] <= byte_value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue: short request queue
// First-in first-out store of decode requests between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue #(
  parameter int unsigned DEPTH = u8u16_pkg::Q_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire u8u16_pkg::job_t  push_job,
  output logic                  full,
  input  wire logic             pop,
  output logic                  nonempty,
  output u8u16_pkg::job_t       head_job
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8u16_pkg::job_t  store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head_job = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back: request decode and unit issue
// Turns one request into one to three UTF-16 units and hands them out one
// per cycle from an output register while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_nonempty,
  input  wire u8u16_pkg::job_t  head_job,
  output logic                  pop,
  output logic [15:0]           code_unit,
  output logic                  run_last,
  output logic                  text_end,
  output logic                  out_valid,
  input  wire logic             out_stall
);

  logic [2:0][15:0]        dec_units;
  logic [1:0]              dec_last;
  logic [3:0][7:0]         b;
  u8u16_pkg::lead_class_t  c0;
  u8u16_pkg::lead_class_t  c1;
  logic                    full_seq;
  logic [20:0]             cp4;
  logic [20:0]             v;

  logic [2:0][15:0]        units;
  logic [1:0]              unit_last;
  logic [1:0]              idx;
  logic                    str_last;
  logic                    fire;

  function automatic logic [15:0] single_unit(input logic [7:0] x);
    return x[7] ? u8u16_pkg::REPL_UNIT : {8'h00, x};
  endfunction

  always_comb begin
    b        = head_job.bytes;
    c0       = u8u16_pkg::lead_class(b[0]);
    c1       = u8u16_pkg::lead_class(b[1]);
    full_seq = (c0 != u8u16_pkg::LC_BAD) &&
               (({1'b0, head_job.last_idx} + 3'd1) == 3'(c0));
    cp4      = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    v        = cp4 - u8u16_pkg::SUPP_BASE;
    dec_units = {3{u8u16_pkg::REPL_UNIT}};
    dec_last  = 2'd0;
    if (full_seq) begin
      unique case (c0)
        u8u16_pkg::LC_ONE:   dec_units[0] = {8'h00, b[0]};
        u8u16_pkg::LC_TWO:   dec_units[0] = {5'b0, b[0][4:0], b[1][5:0]};
        u8u16_pkg::LC_THREE: dec_units[0] = {b[0][3:0], b[1][5:0], b[2][5:0]};
        u8u16_pkg::LC_FOUR: begin
          if (cp4 >= u8u16_pkg::SUPP_BASE) begin
            dec_units[0] = u8u16_pkg::HI_SURR_BASE + {5'b0, v[20:10]};
            dec_units[1] = u8u16_pkg::LO_SURR_BASE + {6'b0, v[9:0]};
            dec_last     = 2'd1;
          end else begin
            dec_units[0] = cp4[15:0];
          end
        end
        default: dec_units[0] = u8u16_pkg::REPL_UNIT;
      endcase
    end else begin
      // Lead is bad or cut short: replace it, then redo the bytes after it
      if (head_job.last_idx == 2'd2 && c1 == u8u16_pkg::LC_TWO) begin
        dec_units[1] = {5'b0, b[1][4:0], b[2][5:0]};
        dec_last     = 2'd1;
      end else if (head_job.last_idx != 2'd0) begin
        dec_units[1] = single_unit(b[1]);
        dec_last     = 2'd1;
        if (head_job.last_idx == 2'd2) begin
          dec_units[2] = single_unit(b[2]);
          dec_last     = 2'd2;
        end
      end
    end
  end

  assign fire      = out_valid && !out_stall;
  assign run_last  = (idx == unit_last);
  assign text_end  = run_last && str_last;
  assign code_unit = units[idx];
  assign pop       = q_nonempty && (!out_valid || (fire && run_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
      unit_last <= 2'd0;
    end else if (pop) begin
      out_valid <= 1'b1;
      idx       <= 2'd0;
      unit_last <= dec_last;
    end else if (fire) begin
      if (run_last) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      units    <= dec_units;
      str_last <= head_job.text_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
// Path: a byte that completes a request is written into the request queue, then
//   loaded into the output register of the back end, which offers its first unit.
// Throughput: one byte per cycle in while the queue is not full; one UTF-16 unit per
//   cycle out while out_stall is low, set by the single output register of the back end.
// The request queue (QDEPTH entries) absorbs output bursts; input stalls only when full.
// Reset (rst, synchronous): clears open sequence, queue and output valid.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder: lenient streaming UTF-8 to UTF-16 transcoder
// Front end gathers the bytes of a sequence, back end decodes and issues units.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_decoder #(
  parameter int unsigned QDEPTH = u8u16_pkg::Q_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte request channel
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  input  wire logic        in_valid,
  output logic             in_stall,
  // unit request channel
  output logic [15:0]      code_unit,
  output logic             run_last,
  output logic             text_end,
  output logic             out_valid,
  input  wire logic        out_stall
);

  u8u16_pkg::job_t  push_job;
  u8u16_pkg::job_t  head_job;
  logic             push;
  logic             q_full;
  logic             q_nonempty;
  logic             pop;

  // Front: lead bytes open a sequence; a request goes out when it completes,
  // when a byte stands alone, or when last_byte closes the string early.
  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Queue decouples the stall of the unit side from the byte side
  u8u16_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head_job (head_job)
  );

  // Back: decode one request into one to three units (surrogate pairs,
  // FFFD for bad or truncated leads) and issue them in order.
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .head_job   (head_job),
    .pop        (pop),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .text_end   (text_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker: port-level checks for the decoder
// Watches the unit channel for ordering of surrogate pairs and flag rules.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic [15:0] code_unit,
  input wire logic        run_last,
  input wire logic        text_end,
  input wire logic        out_valid,
  input wire logic        out_stall
);

  logic out_fire;

  assign out_fire = out_valid && !out_stall;

  // A stalled unit request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_unit) &&
                               $stable(run_last) && $stable(text_end))
    else $error("unit request changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_end |-> run_last)
    else $error("text_end without run_last");

  // High half of a pair is always followed at once by the low half
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_fire && !run_last && (code_unit[15:10] == 6'b110110)
      |=> out_valid && (code_unit[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

  // Units of one request come without gaps
  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_fire && !run_last |=> out_valid)
    else $error("gap inside a unit burst");

  // Empty queue and idle output right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stalled right after reset");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_chk (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the UTF-8 to UTF-16 decoder
// Feeds byte strings (well-formed sequences with random payload, stray and
// truncated sequences, noise) through the valid/stall byte channel and checks
// every UTF-16 unit, with its run_last and text_end flags, against a
// scoreboard that decodes the same bytes on its own.
// ----------------------------------------------------------------------------
module tb_top;

  // one expected UTF-16 unit with its two flags
  typedef struct packed {
    logic [15:0] unit;
    logic        run_last;
    logic        text_end;
  } unit_rec_t;

  // Scoreboard: mirrors the open-sequence state of the decoder and keeps the
  // units that the accepted bytes must produce, oldest first.
  class unit_scoreboard;
    logic [7:0] held [3];     // bytes of the open sequence, lead first
    int         held_n;       // bytes held so far
    int         need_n;       // length of the open sequence
    unit_rec_t  pending_units [$];
    int         errors;
    int         checked;
    int         bytes_in;
    int         strings;

    function new();
      held_n   = 0;
      need_n   = 0;
      errors   = 0;
      checked  = 0;
      bytes_in = 0;
      strings  = 0;
    endfunction

    function int pending();
      return pending_units.size();
    endfunction

    // lead byte class from the top bits only
    function u8u16_pkg::lead_class_t classify(logic [7:0] b);
      if (!b[7]) return u8u16_pkg::LC_ONE;
      if (b[7:5] == 3'b110) return u8u16_pkg::LC_TWO;
      if (b[7:4] == 4'b1110) return u8u16_pkg::LC_THREE;
      if (b[7:3] == 5'b11110) return u8u16_pkg::LC_FOUR;
      return u8u16_pkg::LC_BAD;
    endfunction

    // lenient decode of a closed run of n bytes (n <= 4)
    function void decode_run(input logic [7:0] s [4], input int n,
                             ref logic [15:0] units [$]);
      int                     i;
      int                     len;
      u8u16_pkg::lead_class_t c;
      logic [20:0]            cp;
      logic [20:0]            v;
      i = 0;
      while (i < n) begin
        c   = classify(s[i]);
        len = 1;
        cp  = {13'd0, s[i]};
        if (c == u8u16_pkg::LC_TWO && i + 1 < n) begin
          cp  = {10'd0, s[i][4:0], s[i+1][5:0]};
          len = 2;
        end else if (c == u8u16_pkg::LC_THREE && i + 2 < n) begin
          cp  = {5'd0, s[i][3:0], s[i+1][5:0], s[i+2][5:0]};
          len = 3;
        end else if (c == u8u16_pkg::LC_FOUR && i + 3 < n) begin
          cp  = {s[i][2:0], s[i+1][5:0], s[i+2][5:0], s[i+3][5:0]};
          len = 4;
        end
        if (len == 1 && s[i][7]) begin
          units.insert(units.size(), u8u16_pkg::REPL_UNIT);
        end else if (cp >= u8u16_pkg::SUPP_BASE) begin
          // supplementary plane: surrogate pair
          v = cp - u8u16_pkg::SUPP_BASE;
          units.insert(units.size(),
                       16'(u8u16_pkg::HI_SURR_BASE + {5'd0, v[20:10]}));
          units.insert(units.size(),
                       16'(u8u16_pkg::LO_SURR_BASE + {6'd0, v[9:0]}));
        end else begin
          units.insert(units.size(), cp[15:0]);
        end
        i += len;
      end
      while (units.size() > 3) void'(units.pop_back());
    endfunction

    // an accepted byte request: update the sequence state, queue the units
    function void note_request(logic [7:0] b, logic fin);
      logic [7:0]             s [4];
      logic [15:0]            units [$];
      u8u16_pkg::lead_class_t c;
      unit_rec_t              rec;
      bytes_in++;
      c = classify(b);
      if (!fin) begin
        if (held_n == 0) begin
          if (c != u8u16_pkg::LC_ONE && c != u8u16_pkg::LC_BAD) begin
            held[0] = b;
            held_n  = 1;
            need_n  = int'(c);
            return;
          end
        end else if (held_n + 1 < need_n && held_n < 3) begin
          held[held_n] = b;
          held_n++;
          return;
        end
      end
      for (int k = 0; k < held_n; k++) s[k] = held[k];
      s[held_n] = b;
      decode_run(s, held_n + 1, units);
      held_n = 0;
      need_n = 0;
      if (fin) strings++;
      foreach (units[k]) begin
        rec.unit     = units[k];
        rec.run_last = (k == units.size() - 1);
        rec.text_end = (k == units.size() - 1) && fin;
        pending_units.insert(pending_units.size(), rec);
      end
    endfunction

    // an accepted unit: compare with the oldest expectation
    function void check_unit(logic [15:0] cu, logic rl, logic te);
      unit_rec_t want;
      if (pending_units.size() == 0) begin
        $error("unexpected unit %h: nothing pending", cu);
        errors++;
        return;
      end
      want = pending_units.pop_front();
      checked++;
      if (cu !== want.unit) begin
        $error("code_unit: expected %h, got %h", want.unit, cu);
        errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %b, got %b", want.run_last, rl);
        errors++;
      end
      if (te !== want.text_end) begin
        $error("text_end: expected %b, got %b", want.text_end, te);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] code_unit;
  logic        run_last;
  logic        text_end;
  logic        out_valid;
  logic        out_stall;

  unit_scoreboard sb = new();

  // idle rates in percent, and the receiver's pending hold-off in cycles
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int hold_cycles  = 0;

  utf8_to_utf16_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_unit  (code_unit),
    .run_last   (run_last),
    .text_end   (text_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall picked at each falling edge; a hold-off overrides the
  // random choice and is counted down here.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // Unit monitor: a unit is taken at the rising edge with valid and no stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_unit(code_unit, run_last, text_end);
    end
  end

  // Hard limit on run time.
  initial begin
    #4000000;
    $display("utf8_to_utf16_decoder: mismatch");
    $finish;
  end

  // One byte request. Entered just after a falling edge and left just after
  // one, so in_valid gets one assignment per time step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    last_byte  <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_request(b, fin);
    @(negedge clk);
  endtask

  // Sender pause: drop valid and wait for every pending unit.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Phase change, written away from the falling edge the receiver acts on.
  task automatic set_phase(input int in_pct, input int out_pct, input int hold);
    @(posedge clk);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    hold_cycles  = hold;
    @(negedge clk);
  endtask

  // One random string: mostly well-formed sequences with random payload,
  // with the odd noise byte, bad continuation or truncated tail.
  task automatic send_random_text(inout int sent, input bit ascii_only);
    logic [7:0] seq [$];
    int         chars;
    int         kind;
    int         tail;
    chars = $urandom_range(1, 6);
    repeat (chars) begin
      kind = ascii_only ? 0 : $urandom_range(0, 99);
      tail = 0;
      if (kind < 25) begin
        seq.insert(seq.size(), {1'b0, 7'($urandom)});
      end else if (kind < 45) begin
        seq.insert(seq.size(), {3'b110, 5'($urandom)});
        tail = 1;
      end else if (kind < 65) begin
        seq.insert(seq.size(), {4'b1110, 4'($urandom)});
        tail = 2;
      end else if (kind < 80) begin
        seq.insert(seq.size(), {5'b11110, 3'($urandom)});
        tail = 3;
      end else begin
        seq.insert(seq.size(), 8'($urandom));
      end
      repeat (tail) begin
        // continuation bytes are not checked by the block, so break a few
        if ($urandom_range(0, 9) == 0) seq.insert(seq.size(), 8'($urandom));
        else seq.insert(seq.size(), {2'b10, 6'($urandom)});
      end
    end
    // cut the string inside its last sequence now and then
    if (seq.size() > 1 && $urandom_range(0, 99) < 15) void'(seq.pop_back());
    foreach (seq[k]) send_byte(seq[k], k == seq.size() - 1);
    sent += seq.size();
  endtask

  // Directed strings, {last_byte, byte_value}:
  //   ASCII ends, two/three/four-byte forms with the largest four-byte value,
  //   stray continuation and F8..FF bytes, an overlong form, an encoded
  //   surrogate, a short end whose tail is decoded again, a lone lead at end.
  localparam int NDIR = 23;
  localparam logic [8:0] DIRECTED [NDIR] = '{
    9'h000, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h17F,
    9'h0BF, 9'h0F8, 9'h0FF, 9'h0C0, 9'h080, 9'h0ED, 9'h0A0, 9'h180,
    9'h0F0, 9'h0C2, 9'h1A9,
    9'h1C2
  };

  int random_sent;

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    byte_value = 8'h00;
    last_byte  = 1'b0;
    out_stall  = 1'b0;
    random_sent = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase 1: sender idles 27%, receiver 52%
    set_phase(27, 52, 0);
    foreach (DIRECTED[k]) send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
    while (random_sent < 45) send_random_text(random_sent, 1'b0);
    drain();

    // phase 2: the other way round
    set_phase(52, 27, 0);
    while (random_sent < 95) send_random_text(random_sent, 1'b0);
    drain();

    // phase 3: no idling; first a long receiver hold-off while ASCII keeps
    // coming, so the request queue fills and the byte channel stalls
    set_phase(0, 0, 80);
    repeat (4) send_random_text(random_sent, 1'b1);
    while (random_sent < 147) send_random_text(random_sent, 1'b0);

    drain();
    repeat (8) @(posedge clk);

    $display("%0d bytes in %0d strings sent, %0d UTF-16 units checked",
             sb.bytes_in, sb.strings, sb.checked);
    if (sb.errors == 0) begin
      $display("utf8_to_utf16_decoder: match");
    end else begin
      $display("utf8_to_utf16_decoder: mismatch");
    end
    $finish;
  end

endmodule
